// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Operation and status codes, controller states and the command bundle that
// the controller drives into the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SCORE_W     = 64;
    localparam int DATA_PORT_W = 32;
    localparam int STATUS_W    = 2;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } spq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } spq_status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } spq_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } spq_cmd_t;

endpackage

// ===== src/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: sorted-list priority queue, highest score first
// Holds up to CAPACITY entries of a 64-bit score and a data handle in a row
// of slots kept in descending score order; newer entries go ahead of older
// ones with an equal score.
//
// The request channel carries opcode, entry_score and entry_data under
// in_valid and in_stall. An insert into a full queue is dropped with a full
// status, and a remove from an empty queue returns zeros with an empty status.
// The response channel carries status, removed_score, removed_data and
// occupancy under out_valid and out_stall, one response per request.
// Each request is first captured and then executed, with all slots comparing and
// shifting in parallel. The response is registered when execution ends, and a
// new request is taken only after the previous one has executed.
// A request may be taken while a response still waits in the output
// register; its execution then waits until that response is taken.
// Reset empties the queue and clears both handshakes; slot contents are not
// cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic [spq_pkg::SCORE_W-1:0]           entry_score,
    input  logic [spq_pkg::DATA_PORT_W-1:0]       entry_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [spq_pkg::STATUS_W-1:0]          status,
    output logic [spq_pkg::SCORE_W-1:0]           removed_score,
    output logic [spq_pkg::DATA_PORT_W-1:0]       removed_data,
    output logic [$clog2(CAPACITY+1)-1:0]         occupancy
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spq_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode        (opcode),
        .entry_score   (entry_score),
        .entry_data    (entry_data),
        .status        (status),
        .removed_score (removed_score),
        .removed_data  (removed_data),
        .occupancy     (occupancy)
    );

endmodule

// ===== src/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl: request sequencer of the sorted priority queue
// Accepts one request, starts its execution in the datapath once the result
// register is free, and tracks the validity of the result register.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    spq_state_t state_reg;
    spq_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        in_stall       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/spq_dpath.sv =====
// ----------------------------------------------------------------------------
// spq_dpath: sorted slot array and result register of the priority queue
// Every slot compares its score with the captured request in parallel and
// either holds, loads the new entry or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_dpath #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  spq_pkg::spq_cmd_t                     cmd,
    input  logic                                  opcode,
    input  logic [spq_pkg::SCORE_W-1:0]           entry_score,
    input  logic [spq_pkg::DATA_PORT_W-1:0]       entry_data,
    output logic [spq_pkg::STATUS_W-1:0]          status,
    output logic [spq_pkg::SCORE_W-1:0]           removed_score,
    output logic [spq_pkg::DATA_PORT_W-1:0]       removed_data,
    output logic [$clog2(CAPACITY+1)-1:0]         occupancy
);
    import spq_pkg::*;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int STORE_W = (DATA_WIDTH < DATA_PORT_W) ? DATA_WIDTH : DATA_PORT_W;

    spq_op_t              op_reg;
    logic [SCORE_W-1:0]   score_reg;
    logic [STORE_W-1:0]   data_reg;

    logic [SCORE_W-1:0]   slot_score_reg  [CAPACITY];
    logic [SCORE_W-1:0]   slot_score_next [CAPACITY];
    logic [STORE_W-1:0]   slot_data_reg   [CAPACITY];
    logic [STORE_W-1:0]   slot_data_next  [CAPACITY];
    logic [CAPACITY-1:0]  greater;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    spq_status_t          status_reg;
    spq_status_t          status_next;
    logic [SCORE_W-1:0]   rscore_reg;
    logic [SCORE_W-1:0]   rscore_next;
    logic [STORE_W-1:0]   rdata_reg;
    logic [STORE_W-1:0]   rdata_next;

    logic                 full;
    logic                 empty;
    logic                 do_insert;
    logic                 do_pop;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign do_insert = cmd.exec && (op_reg == OP_INSERT) && !full;
    assign do_pop    = cmd.exec && (op_reg == OP_REMOVE) && !empty;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= spq_op_t'(opcode);
            score_reg <= entry_score;
            data_reg  <= entry_data[STORE_W-1:0];
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_slot
        assign greater[i] = (CNT_W'(i) < count_reg) && (slot_score_reg[i] > score_reg);

        always_comb
        begin
            slot_score_next[i] = slot_score_reg[i];
            slot_data_next[i]  = slot_data_reg[i];
            if (do_insert && !greater[i])
            begin
                if (i == 0)
                begin
                    slot_score_next[i] = score_reg;
                    slot_data_next[i]  = data_reg;
                end
                else if (greater[(i == 0) ? 0 : i - 1])
                begin
                    slot_score_next[i] = score_reg;
                    slot_data_next[i]  = data_reg;
                end
                else
                begin
                    slot_score_next[i] = slot_score_reg[(i == 0) ? 0 : i - 1];
                    slot_data_next[i]  = slot_data_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (do_pop && (i < CAPACITY - 1))
            begin
                slot_score_next[i] = slot_score_reg[(i < CAPACITY - 1) ? i + 1 : i];
                slot_data_next[i]  = slot_data_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end

        always_ff @(posedge clk)
        begin
            slot_score_reg[i] <= slot_score_next[i];
            slot_data_reg[i]  <= slot_data_next[i];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        rscore_next = rscore_reg;
        rdata_next  = rdata_reg;
        if (cmd.exec)
        begin
            status_next = ST_OK;
            rscore_next = '0;
            rdata_next  = '0;
            case (op_reg)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        rscore_next = slot_score_reg[0];
                        rdata_next  = slot_data_reg[0];
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rscore_reg <= rscore_next;
        rdata_reg  <= rdata_next;
    end

    assign status        = status_reg;
    assign removed_score = rscore_reg;
    assign removed_data  = DATA_PORT_W'(rdata_reg);
    assign occupancy     = count_reg;

endmodule

// ===== src/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [spq_pkg::STATUS_W-1:0]          status,
    input logic [spq_pkg::SCORE_W-1:0]           removed_score,
    input logic [spq_pkg::DATA_PORT_W-1:0]       removed_data,
    input logic [$clog2(CAPACITY+1)-1:0]         occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Stalled response was dropped.");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Request taken while the previous one is still executing.");

    a_full_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |->
            (removed_score == '0) && (removed_data == '0) &&
            (occupancy == CNT_W'(CAPACITY)))
        else $error("Full response carries data or a wrong occupancy.");

    a_empty_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |->
            (removed_score == '0) && (removed_data == '0) && (occupancy == '0))
        else $error("Empty response carries data or a nonzero occupancy.");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_EMPTY) || (status == ST_FULL))
        else $error("Response carries an undefined status code.");

endmodule

bind sorted_priority_queue_core spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_score (removed_score),
    .removed_data  (removed_data),
    .occupancy     (occupancy)
);
